// ===== rtl/core/sllt_pkg.sv =====
// shared constants, codes and types of the source location line table
package sllt_pkg;

  localparam int DEF_MAX_ENTRIES = 1024;

  localparam int LOC_W    = 32;
  localparam int LINE_W   = 32;
  localparam int LEN_W    = 16;
  localparam int SPAN_W   = 8;
  localparam int COL_W    = 17;
  localparam int OP_W     = 2;
  localparam int STAT_W   = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = 32;

  // opcodes
  localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
  localparam logic [OP_W-1:0] OP_FINAL   = 2'd1;
  localparam logic [OP_W-1:0] OP_RESOLVE = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FINAL = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_BELOW = 3'd3;
  localparam logic [STAT_W-1:0] STAT_ABOVE = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LOCATION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_LINE    = 1'd1;

  // search request moving down the cell chain
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [LOC_W-1:0] loc;
    logic [LOC_W-1:0] start;
  } srch_tok_t;

endpackage

// ===== rtl/core/sllt_if.sv =====
// request and response channels of the line table
interface sllt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] line_length;
  logic [7:0]  physical_lines;
  logic [31:0] location;

  modport source (output valid, opcode, line_length, physical_lines, location, input ready);
  modport sink (input valid, opcode, line_length, physical_lines, location, output ready);
endinterface

interface sllt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] line_base;
  logic [31:0] line_number;
  logic [16:0] column;

  modport source (output valid, status, line_base, line_number, column, input ready);
  modport sink (input valid, status, line_base, line_number, column, output ready);
endinterface

// ===== rtl/core/sllt_ram.sv =====
// generic simple dual-port ram with registered read
module sllt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/sllt_cell.sv =====
// one search level: holds the starts of entries whose lowest set index bit is its own
module sllt_cell
  import sllt_pkg::*;
#(
  parameter int IW    = 10,
  parameter int LEVEL = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  srch_tok_t        in_tok,
  input  logic [IW-1:0]    in_idx,
  input  logic [IW:0]      used,
  input  logic             wr_en,
  input  logic [IW-1:0]    wr_idx,
  input  logic [LOC_W-1:0] wr_start,
  output srch_tok_t        out_tok,
  output logic [IW-1:0]    out_idx
);

  localparam int B     = IW - 1 - LEVEL;
  localparam int RAW   = (LEVEL > 0) ? LEVEL : 1;
  localparam int RDEPTH = 1 << RAW;

  srch_tok_t        tok;
  logic [IW-1:0]    idx;
  logic [IW-1:0]    cand;
  logic [IW-1:0]    bit_mask;
  logic [IW-1:0]    low_mask;
  logic [IW-1:0]    rd_full;
  logic [IW-1:0]    wr_full;
  logic [RAW-1:0]   rd_addr;
  logic [RAW-1:0]   wr_addr;
  logic             wr_sel;
  logic             take;
  logic [LOC_W-1:0] rdata;

  assign bit_mask = IW'(1) << B;
  assign low_mask = bit_mask - IW'(1);

  // address is the index bits above this level's bit
  assign rd_full = in_idx >> (B + 1);
  assign wr_full = wr_idx >> (B + 1);
  assign rd_addr = rd_full[RAW-1:0];
  assign wr_addr = wr_full[RAW-1:0];
  assign wr_sel  = wr_en && ((wr_idx & bit_mask) != '0) && ((wr_idx & low_mask) == '0);

  sllt_ram #(
    .WIDTH (LOC_W),
    .DEPTH (RDEPTH),
    .AW    (RAW)
  ) u_ram (
    .clk   (clk),
    .we    (wr_sel),
    .waddr (wr_addr),
    .wdata (wr_start),
    .re    (in_tok.valid),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else begin
      tok.valid <= in_tok.valid;
    end
    tok.found <= in_tok.found;
    tok.loc   <= in_tok.loc;
    tok.start <= in_tok.start;
    idx       <= in_idx;
  end

  assign cand = idx | bit_mask;
  assign take = tok.valid && ({1'b0, cand} < used) && (tok.loc >= rdata);

  always_comb begin
    out_tok = tok;
    out_idx = idx;
    if (take) begin
      out_idx       = cand;
      out_tok.start = rdata;
    end
  end

endmodule

// ===== rtl/core/source_location_line_table_unit.sv =====
// Line table that lays source lines end to end in a flat 32-bit location space.
// One request is in flight at a time, and ready stays low until its result has moved
// to the output register. Add, finalise and out-of-range resolve requests go from
// acceptance straight to the pending state, from which their result is loaded into
// the output register. A resolve inside the table runs a binary search down a chain
// of clog2(MAX_ENTRIES) cells, one index bit per cell, each cell owning the entry
// starts whose lowest set index bit it tests; when the search finds an entry, a line
// number read from the line memory follows in the lookup state before the result
// passes to the pending state. A finished result waits while the output register
// still holds an unaccepted one; a new request is accepted while the previous result
// waits in the output register.
module source_location_line_table_unit
  import sllt_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  sllt_req_if.sink             req,
  sllt_rsp_if.source           rsp
);

  localparam int IW = $clog2(MAX_ENTRIES);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_LOOKUP = 2'd2;
  localparam logic [1:0] S_PEND   = 2'd3;

  logic [1:0]        state;
  logic [LOC_W-1:0]  base_location;
  logic [LINE_W-1:0] first_line_number;
  logic [LOC_W-1:0]  next_location;
  logic [IW:0]       used;
  logic              closed;
  logic [LOC_W-1:0]  start0;
  logic [LINE_W-1:0] last_line;
  logic [SPAN_W-1:0] last_span;

  logic [STAT_W-1:0] res_status;
  logic [LOC_W-1:0]  res_base;
  logic [LINE_W-1:0] res_line;
  logic [COL_W-1:0]  res_col;

  logic              accept;
  logic [LOC_W:0]    end_sum;
  logic              full;
  logic              add_ok;
  logic [LINE_W-1:0] num_new;
  logic              in_range;
  logic              launch;
  logic              load;
  logic              search_done;
  logic [LOC_W-1:0]  col_diff;
  logic [LINE_W-1:0] line_rdata;
  logic [STAT_W-1:0] acc_status;

  srch_tok_t         chain_tok [0:IW];
  logic [IW-1:0]     chain_idx [0:IW];

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  assign end_sum  = {1'b0, next_location} + (LOC_W + 1)'(req.line_length);
  assign full     = (used == (IW + 1)'(MAX_ENTRIES)) || end_sum[LOC_W];
  assign add_ok   = accept && (req.opcode == OP_ADD) && !closed && !full;
  assign num_new  = (used == '0) ? first_line_number : last_line + LINE_W'(last_span);
  assign in_range = (req.location >= base_location) && (req.location < next_location);
  assign launch   = accept && (req.opcode == OP_RESOLVE) && in_range;

  always_comb begin
    chain_tok[0].valid = launch;
    chain_tok[0].found = (used != '0) && (req.location >= start0);
    chain_tok[0].loc   = req.location;
    chain_tok[0].start = start0;
    chain_idx[0]       = '0;
  end

  // status of a request as seen at acceptance
  always_comb begin
    acc_status = STAT_OK;
    case (req.opcode)
      OP_ADD: begin
        if (closed) begin
          acc_status = STAT_FINAL;
        end else if (full) begin
          acc_status = STAT_FULL;
        end
      end
      OP_RESOLVE: begin
        if (req.location < base_location) begin
          acc_status = STAT_BELOW;
        end else if (req.location >= next_location) begin
          acc_status = STAT_ABOVE;
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar k = 0; k < IW; k++) begin : g_cell
    sllt_cell #(
      .IW    (IW),
      .LEVEL (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_tok   (chain_tok[k]),
      .in_idx   (chain_idx[k]),
      .used     (used),
      .wr_en    (add_ok),
      .wr_idx   (used[IW-1:0]),
      .wr_start (next_location),
      .out_tok  (chain_tok[k+1]),
      .out_idx  (chain_idx[k+1])
    );
  end

  assign search_done = (state == S_SEARCH) && chain_tok[IW].valid;
  assign col_diff    = chain_tok[IW].loc - chain_tok[IW].start;

  sllt_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_ENTRIES),
    .AW    (IW)
  ) u_line_ram (
    .clk   (clk),
    .we    (add_ok),
    .waddr (used[IW-1:0]),
    .wdata (num_new),
    .re    (search_done),
    .raddr (chain_idx[IW]),
    .rdata (line_rdata)
  );

  assign load = (state == S_PEND) && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      base_location     <= '0;
      first_line_number <= LINE_W'(1);
      next_location     <= '0;
      used              <= '0;
      closed            <= 1'b0;
      rsp.valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BASE_LOCATION: begin
            base_location <= cfg_wdata;
            // an empty table starts where the base points
            if (used == '0) begin
              next_location <= cfg_wdata;
            end
          end
          REG_FIRST_LINE: begin
            first_line_number <= cfg_wdata;
          end
          default: begin
          end
        endcase
      end

      if (add_ok) begin
        used          <= used + (IW + 1)'(1);
        next_location <= end_sum[LOC_W-1:0];
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= launch ? S_SEARCH : S_PEND;
            if (req.opcode == OP_FINAL) begin
              closed <= 1'b1;
            end
          end
        end
        S_SEARCH: begin
          if (chain_tok[IW].valid) begin
            state <= chain_tok[IW].found ? S_LOOKUP : S_PEND;
          end
        end
        S_LOOKUP: begin
          state <= S_PEND;
        end
        S_PEND: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // payload side, no reset
  always_ff @(posedge clk) begin
    if (add_ok) begin
      last_line <= num_new;
      last_span <= req.physical_lines;
      if (used == '0) begin
        start0 <= next_location;
      end
    end

    if (accept) begin
      res_status <= acc_status;
      res_base   <= add_ok ? next_location : '0;
      res_line   <= add_ok ? num_new : '0;
      res_col    <= '0;
    end

    if (search_done) begin
      if (chain_tok[IW].found) begin
        res_col <= col_diff[COL_W-1:0] + COL_W'(1);
      end else begin
        // location sits below the first entry
        res_status <= STAT_BELOW;
      end
    end

    if (state == S_LOOKUP) begin
      res_line <= line_rdata;
    end

    if (load) begin
      rsp.status      <= res_status;
      rsp.line_base   <= res_base;
      rsp.line_number <= res_line;
      rsp.column      <= res_col;
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// line table testbench: queued requests, predictor taken at acceptance and response checker
`timescale 1ns / 100ps

module tb_top
  import sllt_pkg::*;
();

  localparam int TABLE_DEPTH = DEF_MAX_ENTRIES;
  localparam int PHASE_ITEMS = 250;
  localparam int NUM_PHASES = 8;
  localparam int ADD_CAP = 960;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // leaves about four million locations above the first line
  localparam logic [LOC_W-1:0] RUN_BASE = 32'hFFC0_0000;

  typedef struct {
    logic [OP_W-1:0]   opcode;
    logic [LEN_W-1:0]  line_length;
    logic [SPAN_W-1:0] physical_lines;
    logic [LOC_W-1:0]  location;
  } line_req_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [LOC_W-1:0]  line_base;
    logic [LINE_W-1:0] line_number;
    logic [COL_W-1:0]  column;
  } line_answer_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  sllt_req_if req_ch ();
  sllt_rsp_if rsp_ch ();

  source_location_line_table_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // predicted table contents
  logic [LOC_W-1:0]  tbl_base;
  logic [LINE_W-1:0] tbl_first;
  logic [LOC_W-1:0]  tbl_start [TABLE_DEPTH];
  logic [LOC_W-1:0]  tbl_end [TABLE_DEPTH];
  logic [LINE_W-1:0] tbl_line [TABLE_DEPTH];
  logic [SPAN_W-1:0] tbl_span [TABLE_DEPTH];
  int                tbl_used;
  logic [LOC_W-1:0]  tbl_next;
  logic              tbl_closed;

  // layout of the lines queued so far, used to aim resolve requests
  logic [LOC_W-1:0]  gs_start [TABLE_DEPTH];
  logic [LOC_W-1:0]  gs_len [TABLE_DEPTH];
  int                gs_used;
  logic [LOC_W-1:0]  gs_next;

  line_req_t    pending_reqs [$];
  line_answer_t awaited_answers [$];
  line_req_t    cur_req;
  line_answer_t want_ans;
  int           num_queued;
  int           num_answered;
  int           errors;
  int           cycles;
  int           req_gap_pct;
  int           rsp_stall_pct;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic line_answer_t line_table_answer(input line_req_t rq);
    line_answer_t      ans;
    logic [LOC_W:0]    reach;
    logic [LINE_W-1:0] num;
    logic [LOC_W-1:0]  offset;
    logic              hit;
    ans = '{default: '0};
    hit = 1'b0;
    case (rq.opcode)
      OP_ADD: begin
        reach = {1'b0, tbl_next} + (LOC_W + 1)'(rq.line_length);
        if (tbl_closed) begin
          ans.status = STAT_FINAL;
        end else if (tbl_used >= TABLE_DEPTH || reach > {1'b0, {LOC_W{1'b1}}}) begin
          ans.status = STAT_FULL;
        end else begin
          num = (tbl_used == 0) ? tbl_first
                                : tbl_line[tbl_used-1] + LINE_W'(tbl_span[tbl_used-1]);
          tbl_start[tbl_used] = tbl_next;
          tbl_end[tbl_used] = reach[LOC_W-1:0];
          tbl_line[tbl_used] = num;
          tbl_span[tbl_used] = rq.physical_lines;
          tbl_used++;
          ans.status = STAT_OK;
          ans.line_base = tbl_next;
          ans.line_number = num;
          tbl_next = reach[LOC_W-1:0];
        end
      end
      OP_FINAL: begin
        tbl_closed = 1'b1;
      end
      OP_RESOLVE: begin
        if (rq.location < tbl_base) begin
          ans.status = STAT_BELOW;
        end else if (rq.location >= tbl_next) begin
          ans.status = STAT_ABOVE;
        end else begin
          // a base moved below the first line leaves a gap that no line covers
          ans.status = STAT_BELOW;
          for (int k = 0; k < tbl_used && !hit; k++) begin
            if (rq.location >= tbl_start[k] && rq.location < tbl_end[k]) begin
              hit = 1'b1;
              offset = rq.location - tbl_start[k] + LOC_W'(1);
              ans.status = STAT_OK;
              ans.line_number = tbl_line[k];
              ans.column = offset[COL_W-1:0];
            end
          end
        end
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  task automatic report_error(input string msg);
    errors++;
    if (errors <= 50) $display("[%0t] ERROR %s", $time, msg);
  endtask

  // request driver; the prediction is taken when a request is accepted
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) awaited_answers.push_back(line_table_answer(cur_req));
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= req_gap_pct) begin
          cur_req = pending_reqs.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.opcode <= cur_req.opcode;
          req_ch.line_length <= cur_req.line_length;
          req_ch.physical_lines <= cur_req.physical_lines;
          req_ch.location <= cur_req.location;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        num_answered++;
        if (awaited_answers.size() == 0) begin
          report_error($sformatf("response with no request outstanding, status %0d",
                                 rsp_ch.status));
        end else begin
          want_ans = awaited_answers.pop_front();
          if (rsp_ch.status !== want_ans.status)
            report_error($sformatf("status expected %0d got %0d",
                                   want_ans.status, rsp_ch.status));
          if (rsp_ch.line_base !== want_ans.line_base)
            report_error($sformatf("line_base expected %h got %h",
                                   want_ans.line_base, rsp_ch.line_base));
          if (rsp_ch.line_number !== want_ans.line_number)
            report_error($sformatf("line_number expected %h got %h",
                                   want_ans.line_number, rsp_ch.line_number));
          if (rsp_ch.column !== want_ans.column)
            report_error($sformatf("column expected %0d got %0d",
                                   want_ans.column, rsp_ch.column));
        end
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_req(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] len,
                          input logic [SPAN_W-1:0] span, input logic [LOC_W-1:0] loc);
    line_req_t rq;
    rq.opcode = op;
    rq.line_length = len;
    rq.physical_lines = span;
    rq.location = loc;
    pending_reqs.push_back(rq);
    num_queued++;
  endtask

  task automatic add_line(input logic [LEN_W-1:0] len, input logic [SPAN_W-1:0] span);
    if (gs_used < TABLE_DEPTH) begin
      gs_start[gs_used] = gs_next;
      gs_len[gs_used] = LOC_W'(len);
      gs_used++;
      gs_next = gs_next + LOC_W'(len);
    end
    push_req(OP_ADD, len, span, $urandom);
  endtask

  task automatic resolve_at(input logic [LOC_W-1:0] loc);
    push_req(OP_RESOLVE, LEN_W'($urandom), SPAN_W'($urandom), loc);
  endtask

  // mostly lands inside known lines or on their edges
  function automatic logic [LOC_W-1:0] pick_location();
    int               r;
    int               i;
    logic [LOC_W-1:0] len;
    r = $urandom_range(0, 99);
    i = (gs_used > 0) ? $urandom_range(0, gs_used - 1) : 0;
    len = gs_len[i];
    if (gs_used == 0 || r >= 90) return $urandom;
    if (r < 55) return gs_start[i] + ((len == 0) ? 0 : $urandom_range(0, len - 1));
    if (r < 62) return gs_start[i] + len - 1;
    if (r < 70) return gs_start[i] + len;
    if (r < 76) return gs_next - $urandom_range(0, 1);
    if (r < 82) return tbl_base - $urandom_range(0, 1);
    if (r < 86) return {LOC_W{1'b1}};
    return '0;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BASE_LOCATION) begin
      tbl_base = val;
      if (tbl_used == 0) tbl_next = val;
    end else begin
      tbl_first = val;
    end
  endtask

  task automatic wait_drained();
    while (num_answered != num_queued) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin req_gap_pct = 0;  rsp_stall_pct = 0;  end
      1: begin req_gap_pct = 70; rsp_stall_pct = 0;  end
      2: begin req_gap_pct = 0;  rsp_stall_pct = 70; end
      default: begin req_gap_pct = 25; rsp_stall_pct = 25; end
    endcase
  endtask

  initial begin
    int               counted;
    int               pick;
    int               q;
    int               fill;
    logic [LEN_W-1:0] len;
    logic [LOC_W-1:0] room;
    logic [LOC_W-1:0] base_pick;

    req_ch.valid = 1'b0;
    req_ch.opcode = OP_ADD;
    req_ch.line_length = '0;
    req_ch.physical_lines = '0;
    req_ch.location = '0;
    rsp_ch.ready = 1'b0;
    num_queued = 0;
    num_answered = 0;
    errors = 0;
    cycles = 0;
    tbl_base = '0;
    tbl_first = 1;
    tbl_used = 0;
    tbl_next = '0;
    tbl_closed = 1'b0;
    gs_used = 0;
    gs_next = '0;
    set_idling(0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table: nothing resolves, unused opcode answers all zeros
    resolve_at('0);
    push_req(OP_UNUSED, '1, '1, '1);
    wait_drained();

    // base at the very top while empty drags the next free location along
    write_reg(REG_BASE_LOCATION, {LOC_W{1'b1}});
    resolve_at('0);
    resolve_at(32'hFFFF_FFFF);
    resolve_at(32'hFFFF_FFFE);
    wait_drained();

    write_reg(REG_BASE_LOCATION, RUN_BASE);
    write_reg(REG_FIRST_LINE, 32'hFFFF_FFFF);
    gs_next = RUN_BASE;
    // zero-length first line, then line numbers wrap past the top
    add_line(16'd0, 8'hFF);
    add_line(16'd1, 8'h00);
    add_line(16'hFFFF, 8'h01);
    add_line(16'd5, 8'hFF);
    resolve_at(RUN_BASE - 1);
    resolve_at(RUN_BASE);
    resolve_at(RUN_BASE + 1);
    resolve_at(RUN_BASE + 65535);
    resolve_at(RUN_BASE + 65536);
    resolve_at(RUN_BASE + 65540);
    resolve_at(RUN_BASE + 65541);
    resolve_at(32'hFFFF_FFFF);
    resolve_at('0);
    push_req(OP_UNUSED, '0, '0, '0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: base_pick = RUN_BASE;
        1: base_pick = '0;
        2: base_pick = RUN_BASE - 32'd1000;
        3: base_pick = gs_start[gs_used / 2];
        4: base_pick = {LOC_W{1'b1}};
        5: base_pick = $urandom;
        6: base_pick = RUN_BASE;
        default: base_pick = gs_next;
      endcase
      write_reg(REG_BASE_LOCATION, base_pick);
      write_reg(REG_FIRST_LINE, (ph == 1) ? 32'hFFFF_FFFF : (ph == 4) ? 32'd0 : $urandom);
      set_idling(ph % 4);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          push_req(OP_UNUSED, LEN_W'($urandom), SPAN_W'($urandom), $urandom);
        end else begin
          counted++;
          if (pick < 48 && gs_used < ADD_CAP) begin
            q = $urandom_range(0, 99);
            if (q < 10) len = '0;
            else if (q < 60) len = LEN_W'($urandom_range(1, 15));
            else if (q < 92) len = LEN_W'($urandom_range(0, 1023));
            else len = LEN_W'($urandom);
            // keep the top of the location space for the closing requests
            if (32'hFFFF_FFFF - gs_next < 32'h0010_0000) len = LEN_W'($urandom_range(0, 15));
            add_line(len, SPAN_W'($urandom));
          end else begin
            resolve_at(pick_location());
          end
        end
      end
    end

    // run the space up to its top, then fill every entry, then close
    wait_drained();
    write_reg(REG_BASE_LOCATION, RUN_BASE);
    set_idling(3);
    room = 32'hFFFF_FFFF - tbl_next;
    fill = tbl_used;
    while (room > 32'd65535 && fill < TABLE_DEPTH - 4) begin
      add_line(16'hFFFF, SPAN_W'($urandom));
      room = room - 32'd65535;
      fill++;
    end
    add_line(room[LEN_W-1:0], SPAN_W'($urandom));
    fill++;
    add_line(16'd1, SPAN_W'($urandom));
    add_line(16'hFFFF, SPAN_W'($urandom));
    resolve_at(32'hFFFF_FFFE);
    resolve_at(32'hFFFF_FFFF);
    while (fill < TABLE_DEPTH) begin
      add_line(16'd0, SPAN_W'($urandom));
      if ($urandom_range(0, 3) == 0) resolve_at(pick_location());
      fill++;
    end
    add_line(16'd0, SPAN_W'($urandom));
    push_req(OP_FINAL, LEN_W'($urandom), SPAN_W'($urandom), $urandom);
    add_line(16'd3, SPAN_W'($urandom));
    push_req(OP_FINAL, LEN_W'($urandom), SPAN_W'($urandom), $urandom);
    repeat (4) resolve_at(pick_location());
    push_req(OP_UNUSED, LEN_W'($urandom), SPAN_W'($urandom), $urandom);

    wait_drained();
    if (errors == 0 && awaited_answers.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sllt_pkg.sv
rtl/core/sllt_if.sv
rtl/core/sllt_ram.sv
rtl/core/sllt_cell.sv
rtl/core/source_location_line_table_unit.sv
dv/tb_top.sv
